// File: rtl/core/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// lzwd_pkg: shared constants and types of the LZW decoder
// Code widths, dictionary layout, string limits and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package lzwd_pkg;

  localparam int CODE_BITS_MAX    = 16;
  localparam int NARROW_BITS      = 12;
  localparam int MAX_STRING_LEN   = 512;
  localparam int BYTES_PER_RESULT = 8;
  localparam int RESULT_CAP       = 64;

  localparam int EMIT_LIMIT = (MAX_STRING_LEN < RESULT_CAP * BYTES_PER_RESULT) ?
                              MAX_STRING_LEN : RESULT_CAP * BYTES_PER_RESULT;

  localparam int DICT_DEPTH = 1 << CODE_BITS_MAX;
  localparam int LEN_W      = 16;
  localparam int ENTRY_W    = CODE_BITS_MAX + 8 + LEN_W;
  localparam int STACK_AW   = $clog2(EMIT_LIMIT);
  localparam int NCNT_W     = $clog2(EMIT_LIMIT + 1);
  localparam int TOTAL_W    = LEN_W + 1;
  localparam int GROUP_W    = 8 * BYTES_PER_RESULT;
  localparam int BCNT_W     = 4;

  localparam logic [CODE_BITS_MAX-1:0] CLEAR_WIDE   = {CODE_BITS_MAX{1'b1}};
  localparam logic [CODE_BITS_MAX-1:0] CLEAR_NARROW =
      CODE_BITS_MAX'((1 << NARROW_BITS) - 1);
  localparam logic [CODE_BITS_MAX-1:0] FIRST_FREE   = CODE_BITS_MAX'(256);
  localparam logic [LEN_W-1:0]         LEN_SAT      = {LEN_W{1'b1}};

  typedef logic [CODE_BITS_MAX-1:0] code_t;

  typedef struct packed {
    code_t            prefix;
    logic [7:0]       last;
    logic [LEN_W-1:0] len;
  } dict_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK_MEM,
    ST_WALK_LIT,
    ST_FIN,
    ST_EMIT_RD,
    ST_EMIT_CAP,
    ST_PUSH
  } state_t;

endpackage
`default_nettype wire

// File: rtl/core/lzwd_ram.sv
// ----------------------------------------------------------------------------
// lzwd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/lzw_decoder_core.sv
// ----------------------------------------------------------------------------
// lzw_decoder_core: LZW code to byte-string decoder
// Input channel: one code word per handshake (in_valid / in_stall).
// Output channel: words of up to 8 bytes, first byte in bits 7..0, with a
//   byte count, a last mark on the final word of a code and a status bit
//   that flags a string cut to 512 bytes.
// Config channel: cfg_wide_codes selects 12-bit (0) or 16-bit (1) codes;
//   write it only while the block is idle.
// After accepting a code, the sequencer walks the prefix chain (ST_WALK_MEM,
// one read of the dictionary RAM per entry), writes the closing literal
// (ST_WALK_LIT) and finishes (ST_FIN). Each output word then takes a stack
// read setup (ST_EMIT_RD), one stack read per byte (ST_EMIT_CAP) and a load
// of the output register (ST_PUSH). A clear or first code goes straight from
// acceptance to the output register load.
// The block takes one code at a time: in_stall is high until the last word
// of the current code is loaded in the output register.
// A stalled receiver holds the output register, and the block waits there.
// Reset (synchronous, rst_n low) empties the table (next free code 256),
// arms the first-code rule and selects 12-bit codes; RAM contents are not
// cleared, since only entries already written are ever read.
// ----------------------------------------------------------------------------
`default_nettype none
module lzw_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // code input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_code_word,
  // byte output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_byte_group,
  output logic [3:0]       out_byte_count,
  output logic             out_last_of_run,
  output logic             out_status,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_wide_codes
);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  lzwd_pkg::state_t state_r, state_nxt;

  logic                wide_r;
  lzwd_pkg::code_t     prev_code_r, prev_code_nxt;
  logic [lzwd_pkg::LEN_W-1:0] prev_len_r, prev_len_nxt;
  lzwd_pkg::code_t     next_free_r, next_free_nxt;
  logic                awaiting_r, awaiting_nxt;

  // per-code working registers
  lzwd_pkg::code_t     code_r, code_nxt;      // code as received (masked)
  lzwd_pkg::code_t     cur_r, cur_nxt;        // chain position
  logic [lzwd_pkg::LEN_W-1:0]   pos_r, pos_nxt;
  logic [lzwd_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic                unk_r, unk_nxt;        // code not yet in table
  logic                first_step_r, first_step_nxt;
  logic [7:0]          first_r, first_nxt;    // first byte of walked string

  // emit registers
  logic [lzwd_pkg::NCNT_W-1:0]  idx_r, idx_nxt;
  logic [lzwd_pkg::NCNT_W-1:0]  n_r, n_nxt;
  logic                flag_r, flag_nxt;
  logic [lzwd_pkg::GROUP_W-1:0] group_r, group_nxt;
  logic [lzwd_pkg::BCNT_W-1:0]  cnt_r, cnt_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [lzwd_pkg::GROUP_W-1:0] out_group_r, out_group_nxt;
  logic [lzwd_pkg::BCNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_status_r, out_status_nxt;

  // --------------------------------------------------------------------------
  // Memories: dictionary (prefix, last byte, length) and reverse stack
  // --------------------------------------------------------------------------
  logic                    dict_we;
  lzwd_pkg::code_t         dict_waddr;
  lzwd_pkg::dict_entry_t   dict_wdata;
  lzwd_pkg::code_t         dict_raddr;
  logic [lzwd_pkg::ENTRY_W-1:0] dict_rbits;
  lzwd_pkg::dict_entry_t   dict_rd;

  logic                    stk_we;
  logic [lzwd_pkg::STACK_AW-1:0] stk_waddr;
  logic [7:0]              stk_wdata;
  logic [lzwd_pkg::STACK_AW-1:0] stk_raddr;
  logic [7:0]              stk_rdata;

  lzwd_ram #(
    .WIDTH (lzwd_pkg::ENTRY_W),
    .DEPTH (lzwd_pkg::DICT_DEPTH)
  ) u_dict (
    .clk   (clk),
    .we    (dict_we),
    .waddr (dict_waddr),
    .wdata (dict_wdata),
    .raddr (dict_raddr),
    .rdata (dict_rbits)
  );

  assign dict_rd = lzwd_pkg::dict_entry_t'(dict_rbits);

  lzwd_ram #(
    .WIDTH (8),
    .DEPTH (lzwd_pkg::EMIT_LIMIT)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  logic            in_acc;
  logic            out_free;
  lzwd_pkg::code_t clear_code;
  lzwd_pkg::code_t code_in;

  assign in_stall   = (state_r != lzwd_pkg::ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign cfg_ready  = 1'b1;
  assign clear_code = wide_r ? lzwd_pkg::CLEAR_WIDE : lzwd_pkg::CLEAR_NARROW;
  assign code_in    = in_code_word & clear_code;

  assign out_valid       = out_valid_r;
  assign out_byte_group  = out_group_r;
  assign out_byte_count  = out_cnt_r;
  assign out_last_of_run = out_last_r;
  assign out_status      = out_status_r;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    lzwd_pkg::code_t            walk_c;
    logic [lzwd_pkg::LEN_W-1:0] pe;
    logic [lzwd_pkg::LEN_W-1:0] sat_len;
    logic [lzwd_pkg::TOTAL_W-1:0] tot_eff;
    logic                       add_ok;

    state_nxt      = state_r;
    prev_code_nxt  = prev_code_r;
    prev_len_nxt   = prev_len_r;
    next_free_nxt  = next_free_r;
    awaiting_nxt   = awaiting_r;
    code_nxt       = code_r;
    cur_nxt        = cur_r;
    pos_nxt        = pos_r;
    total_nxt      = total_r;
    unk_nxt        = unk_r;
    first_step_nxt = first_step_r;
    first_nxt      = first_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    flag_nxt       = flag_r;
    group_nxt      = group_r;
    cnt_nxt        = cnt_r;

    out_valid_nxt  = out_valid_r && out_stall;
    out_group_nxt  = out_group_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;

    dict_we    = 1'b0;
    dict_waddr = next_free_r;
    dict_wdata = '{prefix: prev_code_r, last: first_r, len: prev_len_r};
    dict_raddr = cur_r;
    stk_we     = 1'b0;
    stk_waddr  = pos_r[lzwd_pkg::STACK_AW-1:0];
    stk_wdata  = first_r;
    stk_raddr  = idx_r[lzwd_pkg::STACK_AW-1:0];

    walk_c  = code_in;
    pe      = first_step_r ? (dict_rd.len - 1'b1) : pos_r;
    sat_len = (prev_len_r == lzwd_pkg::LEN_SAT) ? lzwd_pkg::LEN_SAT
                                                : prev_len_r + 1'b1;
    tot_eff = unk_r ? total_r + 1'b1 : total_r;
    add_ok  = (next_free_r < clear_code);

    case (state_r)
      lzwd_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (code_in == clear_code) begin
            next_free_nxt = lzwd_pkg::FIRST_FREE;
            awaiting_nxt  = 1'b1;
            group_nxt     = '0;
            cnt_nxt       = '0;
            idx_nxt       = '0;
            n_nxt         = '0;
            flag_nxt      = 1'b0;
            state_nxt     = lzwd_pkg::ST_PUSH;
          end else if (awaiting_r) begin
            // first code after clear: its low byte, whatever the code
            group_nxt     = lzwd_pkg::GROUP_W'(code_in[7:0]);
            cnt_nxt       = lzwd_pkg::BCNT_W'(1);
            idx_nxt       = lzwd_pkg::NCNT_W'(1);
            n_nxt         = lzwd_pkg::NCNT_W'(1);
            flag_nxt      = 1'b0;
            prev_code_nxt = lzwd_pkg::code_t'(code_in[7:0]);
            prev_len_nxt  = lzwd_pkg::LEN_W'(1);
            awaiting_nxt  = 1'b0;
            state_nxt     = lzwd_pkg::ST_PUSH;
          end else begin
            code_nxt = code_in;
            if (code_in < 16'd256 || code_in < next_free_r) begin
              unk_nxt = 1'b0;
              walk_c  = code_in;
            end else begin
              unk_nxt = 1'b1;
              walk_c  = prev_code_r;
            end
            cur_nxt = walk_c;
            if (walk_c < 16'd256) begin
              pos_nxt   = '0;
              total_nxt = lzwd_pkg::TOTAL_W'(1);
              state_nxt = lzwd_pkg::ST_WALK_LIT;
            end else begin
              dict_raddr     = walk_c;
              first_step_nxt = 1'b1;
              state_nxt      = lzwd_pkg::ST_WALK_MEM;
            end
          end
        end
      end

      lzwd_pkg::ST_WALK_MEM: begin
        // entry for cur_r is on the RAM output
        if (first_step_r) begin
          total_nxt = lzwd_pkg::TOTAL_W'(dict_rd.len);
        end
        stk_waddr      = pe[lzwd_pkg::STACK_AW-1:0];
        stk_wdata      = dict_rd.last;
        stk_we         = (pe < lzwd_pkg::LEN_W'(lzwd_pkg::EMIT_LIMIT));
        pos_nxt        = pe - 1'b1;
        cur_nxt        = dict_rd.prefix;
        first_step_nxt = 1'b0;
        dict_raddr     = dict_rd.prefix;
        if (dict_rd.prefix < 16'd256) begin
          state_nxt = lzwd_pkg::ST_WALK_LIT;
        end
      end

      lzwd_pkg::ST_WALK_LIT: begin
        stk_waddr = pos_r[lzwd_pkg::STACK_AW-1:0];
        stk_wdata = cur_r[7:0];
        stk_we    = (pos_r < lzwd_pkg::LEN_W'(lzwd_pkg::EMIT_LIMIT));
        first_nxt = cur_r[7:0];
        state_nxt = lzwd_pkg::ST_FIN;
      end

      lzwd_pkg::ST_FIN: begin
        // unknown code: append the first byte of the previous string
        if (unk_r) begin
          stk_waddr = total_r[lzwd_pkg::STACK_AW-1:0];
          stk_wdata = first_r;
          stk_we    = (total_r < lzwd_pkg::TOTAL_W'(lzwd_pkg::EMIT_LIMIT));
        end
        if (add_ok) begin
          dict_we       = 1'b1;
          dict_waddr    = next_free_r;
          dict_wdata    = '{prefix: prev_code_r, last: first_r, len: sat_len};
          next_free_nxt = next_free_r + 1'b1;
        end
        if (!unk_r) begin
          prev_code_nxt = code_r;
          prev_len_nxt  = total_r[lzwd_pkg::LEN_W-1:0];
        end else if (add_ok) begin
          prev_code_nxt = next_free_r;
          prev_len_nxt  = sat_len;
        end
        if (tot_eff > lzwd_pkg::TOTAL_W'(lzwd_pkg::EMIT_LIMIT)) begin
          n_nxt    = lzwd_pkg::NCNT_W'(lzwd_pkg::EMIT_LIMIT);
          flag_nxt = 1'b1;
        end else begin
          n_nxt    = tot_eff[lzwd_pkg::NCNT_W-1:0];
          flag_nxt = 1'b0;
        end
        idx_nxt   = '0;
        cnt_nxt   = '0;
        group_nxt = '0;
        state_nxt = lzwd_pkg::ST_EMIT_RD;
      end

      lzwd_pkg::ST_EMIT_RD: begin
        stk_raddr = idx_r[lzwd_pkg::STACK_AW-1:0];
        state_nxt = lzwd_pkg::ST_EMIT_CAP;
      end

      lzwd_pkg::ST_EMIT_CAP: begin
        group_nxt[cnt_r[2:0]*8 +: 8] = stk_rdata;
        cnt_nxt   = cnt_r + 1'b1;
        idx_nxt   = idx_r + 1'b1;
        stk_raddr = idx_nxt[lzwd_pkg::STACK_AW-1:0];
        if (cnt_nxt == lzwd_pkg::BCNT_W'(lzwd_pkg::BYTES_PER_RESULT) ||
            idx_nxt == n_r) begin
          state_nxt = lzwd_pkg::ST_PUSH;
        end
      end

      lzwd_pkg::ST_PUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_group_nxt  = group_r;
          out_cnt_nxt    = cnt_r;
          out_last_nxt   = (idx_r == n_r);
          out_status_nxt = flag_r;
          group_nxt      = '0;
          cnt_nxt        = '0;
          state_nxt      = (idx_r == n_r) ? lzwd_pkg::ST_IDLE : lzwd_pkg::ST_EMIT_RD;
        end
      end

      default: begin
        state_nxt = lzwd_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lzwd_pkg::ST_IDLE;
      wide_r      <= 1'b0;
      prev_code_r <= '0;
      prev_len_r  <= lzwd_pkg::LEN_W'(1);
      next_free_r <= lzwd_pkg::FIRST_FREE;
      awaiting_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_code_r <= prev_code_nxt;
      prev_len_r  <= prev_len_nxt;
      next_free_r <= next_free_nxt;
      awaiting_r  <= awaiting_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        wide_r <= cfg_wide_codes;
      end
    end
  end

  always_ff @(posedge clk) begin
    code_r       <= code_nxt;
    cur_r        <= cur_nxt;
    pos_r        <= pos_nxt;
    total_r      <= total_nxt;
    unk_r        <= unk_nxt;
    first_step_r <= first_step_nxt;
    first_r      <= first_nxt;
    idx_r        <= idx_nxt;
    n_r          <= n_nxt;
    flag_r       <= flag_nxt;
    group_r      <= group_nxt;
    cnt_r        <= cnt_nxt;
    out_group_r  <= out_group_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cnt_r <= lzwd_pkg::BCNT_W'(lzwd_pkg::BYTES_PER_RESULT)))
    else $error("output byte count above word size");

  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != lzwd_pkg::ST_IDLE))
    else $error("accepted code left no work");

  a_fin_total: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lzwd_pkg::ST_FIN) |-> (total_r != '0))
    else $error("walk finished with zero length");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lzwd_pkg::ST_EMIT_CAP) |-> (idx_r < n_r))
    else $error("stack read past string end");

endmodule
`default_nettype wire

// File: dv/lzw_decoder_checker.sv
// ----------------------------------------------------------------------------
// lzw_decoder_checker: output checker of the LZW decoder core
// Follows the code, word and config handshakes, decodes each accepted code
// with its own copy of the table and compares every output word in order.
// ----------------------------------------------------------------------------
`default_nettype none
module lzw_decoder_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [15:0] in_code_word,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [63:0] out_byte_group,
  input  wire logic [3:0]  out_byte_count,
  input  wire logic        out_last_of_run,
  input  wire logic        out_status,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic        cfg_wide_codes,
  output int               fail_count,
  output int               words_pending,
  output int               words_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0] group;
    logic [3:0]  count;
    logic        last;
    logic        status;
  } out_word_t;

  out_word_t   words_due[$];
  logic [15:0] tbl_prefix [lzwd_pkg::DICT_DEPTH];
  logic [7:0]  tbl_last   [lzwd_pkg::DICT_DEPTH];
  int unsigned tbl_len    [lzwd_pkg::DICT_DEPTH];
  logic [7:0]  str_buf    [lzwd_pkg::EMIT_LIMIT];
  int unsigned next_code, prev_code;
  logic        first_pending, wide_mode;

  function automatic int unsigned str_length(int unsigned c);
    return (c < 256) ? 1 : tbl_len[c];
  endfunction

  // rebuild string c into str_buf back to front; returns length, sets head byte
  function automatic int unsigned unwind(int unsigned c, output logic [7:0] head);
    int unsigned total, pos;
    logic [7:0] b;
    total = str_length(c);
    pos = total - 1;
    forever begin
      b = (c < 256) ? c[7:0] : tbl_last[c];
      if (pos < lzwd_pkg::EMIT_LIMIT) str_buf[pos] = b;
      if (c < 256) break;
      c = tbl_prefix[c];
      pos--;
    end
    head = b;
    return total;
  endfunction

  function automatic void add_entry(int unsigned clr, int unsigned pfx, logic [7:0] b);
    int unsigned l;
    if (next_code >= clr || next_code >= lzwd_pkg::DICT_DEPTH) return;
    l = str_length(pfx) + 1;
    if (l > 16'hFFFF) l = 16'hFFFF;
    tbl_prefix[next_code] = pfx[15:0];
    tbl_last[next_code]   = b;
    tbl_len[next_code]    = l;
    next_code++;
  endfunction

  function automatic void queue_string(int unsigned total);
    int unsigned n, i, j;
    out_word_t w;
    n = (total < lzwd_pkg::EMIT_LIMIT) ? total : lzwd_pkg::EMIT_LIMIT;
    i = 0;
    while (i < n) begin
      w.group = '0;
      for (j = 0; j < lzwd_pkg::BYTES_PER_RESULT && i < n; j++) begin
        w.group[8*j +: 8] = str_buf[i];
        i++;
      end
      w.count  = j[3:0];
      w.last   = (i >= n);
      w.status = (total > lzwd_pkg::EMIT_LIMIT);
      words_due.push_back(w);
    end
  endfunction

  function automatic void decode_code(logic [15:0] raw);
    int unsigned clr, code, total, fresh;
    logic [7:0] head;
    out_word_t w;
    clr  = wide_mode ? 32'hFFFF : 32'h0FFF;
    code = raw & clr;
    if (code == clr) begin
      next_code = 256;
      first_pending = 1'b1;
      w.group = '0; w.count = '0; w.last = 1'b1; w.status = 1'b0;
      words_due.push_back(w);
      return;
    end
    if (first_pending) begin
      str_buf[0] = code[7:0];
      prev_code = code & 8'hFF;
      first_pending = 1'b0;
      queue_string(1);
      return;
    end
    if (code < 256 || code < next_code) begin
      total = unwind(code, head);
      add_entry(clr, prev_code, head);
      prev_code = code;
    end else begin
      // code not yet defined: previous string plus its own head byte
      total = unwind(prev_code, head);
      if (total < lzwd_pkg::EMIT_LIMIT) str_buf[total] = head;
      total++;
      if (next_code < clr && next_code < lzwd_pkg::DICT_DEPTH) begin
        fresh = next_code;
        add_entry(clr, prev_code, head);
        prev_code = fresh;
      end
    end
    queue_string(total);
  endfunction

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      next_code     = 256;
      prev_code     = 0;
      first_pending = 1'b1;
      wide_mode     = 1'b0;
      words_due.delete();
      fail_count <= 0;
      words_seen <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        words_seen <= words_seen + 1;
        if (words_due.size() == 0) begin
          if (fail_count < 10) $display("%0t: unexpected output word %h", $realtime,
                                        out_byte_group);
          fail_count <= fail_count + 1;
        end else begin
          e = words_due.pop_front();
          if (e.group !== out_byte_group || e.count !== out_byte_count ||
              e.last !== out_last_of_run || e.status !== out_status) begin
            if (fail_count < 10)
              $display("%0t: word mismatch exp %h/%0d/%b/%b got %h/%0d/%b/%b", $realtime,
                       e.group, e.count, e.last, e.status, out_byte_group,
                       out_byte_count, out_last_of_run, out_status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) decode_code(in_code_word);
      if (cfg_valid && cfg_ready) wide_mode = cfg_wide_codes;
    end
    words_pending <= words_due.size();
  end
endmodule
`default_nettype wire

// File: dv/lzw_decoder_core_test.sv
// ----------------------------------------------------------------------------
// lzw_decoder_core_test: testbench top of the LZW decoder core
// Drives codes in both code widths (directed, a growing string and random
// streams), throttles the output side and reports the verdict.
// ----------------------------------------------------------------------------
`default_nettype none
module lzw_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  logic [15:0] in_code_word;
  logic        out_valid, out_stall;
  logic [63:0] out_byte_group;
  logic [3:0]  out_byte_count;
  logic        out_last_of_run, out_status;
  logic        cfg_valid, cfg_ready, cfg_wide_codes;
  int          fail_count, words_pending, words_seen;

  // stimulus knobs and counters; idle_on and squeeze_* shared with the stall process
  logic        idle_on;        // random gaps on both sides
  logic        squeeze_req;    // ask for one long receiver hold-off
  logic        squeeze_done;
  int          squeeze_left;
  int          codes_sent;
  int unsigned cycle_count;
  int unsigned code_limit;     // rough next free code, for well-formed streams

  lzw_decoder_core i_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_code_word,
    .out_valid, .out_stall, .out_byte_group, .out_byte_count,
    .out_last_of_run, .out_status,
    .cfg_valid, .cfg_ready, .cfg_wide_codes
  );

  lzw_decoder_checker i_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_code_word,
    .out_valid, .out_stall, .out_byte_group, .out_byte_count,
    .out_last_of_run, .out_status,
    .cfg_valid, .cfg_ready, .cfg_wide_codes,
    .fail_count, .words_pending, .words_seen
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: far above the slowest legal run
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 4_000_000) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // receiver: random stall, or one long hold-off when asked
  initial begin
    out_stall    = 1'b0;
    squeeze_left = 0;
    squeeze_done = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeeze_done && squeeze_left == 0) begin
        squeeze_left = 400;
        squeeze_done = 1'b1;
      end
      if (squeeze_left > 0) begin
        squeeze_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 32);
      end
    end
  end

  // one code word; a gap may come first, accept sampled on the falling edge
  task automatic send_code(input logic [15:0] c);
    logic taken;
    while (idle_on && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_code_word <= c;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    codes_sent++;
    // track the table size the way a well-formed stream grows it
    if ((c & (cfg_wide_codes ? 16'hFFFF : 16'h0FFF)) == (cfg_wide_codes ? 16'hFFFF : 16'h0FFF))
      code_limit = 255;
    else if (code_limit < (cfg_wide_codes ? 65534 : 4094))
      code_limit++;
  endtask

  // wait for the block to go quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // config write, only ever called while the block is idle
  task automatic set_width(input logic wide);
    logic taken;
    cfg_valid      <= 1'b1;
    cfg_wide_codes <= wide;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly defined codes or the next one to be defined, some clears and noise
  task automatic random_stream(input int n, input logic wide);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 6)       send_code(wide ? 16'hFFFF : 16'h0FFF);
      else if (r < 14) send_code(16'($urandom));
      else if (r < 40) send_code(16'($urandom_range(255)));
      else             send_code(16'($urandom_range(code_limit + 1)));
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_code_word   = '0;
    cfg_valid      = 1'b0;
    cfg_wide_codes = 1'b0;
    idle_on        = 1'b1;
    squeeze_req    = 1'b0;
    codes_sent     = 0;
    code_limit     = 255;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, narrow codes from reset: first code above the literals,
    // clear code, masked upper bits, undefined next code
    set_width(1'b0);
    send_code(16'h0ABC);
    send_code(16'h0041);
    send_code(16'h0042);
    send_code(16'h0100);
    send_code(16'h0103);
    send_code(16'h0000);
    send_code(16'h00FF);
    send_code(16'hF041);
    send_code(16'h0FFE);
    send_code(16'hFFFF);
    send_code(16'h0FFF);
    send_code(16'h0020);
    send_code(16'h0101);
    drain();

    // directed, wide codes: old narrow clear is now an ordinary code
    set_width(1'b1);
    send_code(16'hFFFF);
    send_code(16'hFFFE);
    send_code(16'h0FFF);
    send_code(16'h8000);
    send_code(16'h0102);
    send_code(16'h0055);
    send_code(16'h0103);
    send_code(16'hFFFF);
    drain();

    // one growing string over many output words; first stretch gap-free
    set_width(1'b0);
    idle_on = 1'b0;
    send_code(16'h0FFF);
    send_code(16'h0041);
    for (int k = 0; k < 40; k++) begin
      if (k == 20) idle_on = 1'b1;
      send_code(16'(256 + k));
    end
    send_code(16'h0FFF);
    drain();

    // random streams in both widths, receiver held off once in the first
    code_limit = 255;
    send_code(16'h0FFF);
    squeeze_req = 1'b1;
    random_stream(60, 1'b0);
    squeeze_req = 1'b0;
    drain();
    set_width(1'b1);
    code_limit = 255;
    send_code(16'hFFFF);
    random_stream(60, 1'b1);
    drain();
    set_width(1'b0);
    drain();

    $display("Sent %0d codes in both code widths, checked %0d output words", codes_sent,
             words_seen);
    $display("Covered clears, first codes, undefined codes, multi-word strings, "
             , "width changes and a long receiver hold-off");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
rtl/core/lzwd_pkg.sv
rtl/core/lzwd_ram.sv
rtl/core/lzw_decoder_core.sv
dv/lzw_decoder_checker.sv
dv/lzw_decoder_core_test.sv
